@@ src/lppc_pkg.sv @@
// shared types, widths and codes of the layered polygon pixel classifier
package lppc_pkg;

  // default sizes of the shape tables
  localparam int MAX_LAYERS_DEF = 32;
  localparam int MAX_SIDES_DEF  = 128;

  // fixed point format of coordinates and radii
  localparam int FRAC_BITS = 4;

  // field widths
  localparam int REQ_W  = 2;
  localparam int LSEL_W = 5;
  localparam int VSEL_W = 7;
  localparam int SIDE_W = 8;
  localparam int CRD_W  = 16;
  localparam int RAD_W  = 15;
  localparam int PIX_W  = 10;
  localparam int HIT_W  = 5;
  localparam int LCNT_W = 6;

  // stream widths
  localparam int S_TDATA_W = 104;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 8;
  localparam int M_TUSER_W = 1;

  // datapath widths
  localparam int PXS_W = PIX_W + FRAC_BITS;                      // scaled pixel
  localparam int REL_W = ((PXS_W > CRD_W) ? PXS_W : CRD_W) + 1;  // pixel minus center
  localparam int DIF_W = REL_W + 1;                              // vertex minus pixel
  localparam int PRD_W = 2 * DIF_W;
  localparam int CRS_W = PRD_W + 1;
  localparam int SUM_W = CRS_W + 2;
  localparam int SQ_W  = 2 * RAD_W;
  localparam int EP_W  = 2 * SQ_W;
  localparam int ES_W  = EP_W + 1;

  // request kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_LAYER  = 2'd0,
    REQ_VERTEX = 2'd1,
    REQ_PIXEL  = 2'd2
  } req_e;

  // one decoded request as it waits in the queue
  typedef struct packed {
    req_e                    kind;
    logic [LSEL_W-1:0]       layer_sel;
    logic [VSEL_W-1:0]       vertex_sel;
    logic [SIDE_W-1:0]       side_total;
    logic signed [CRD_W-1:0] coord_x;
    logic signed [CRD_W-1:0] coord_y;
    logic [RAD_W-1:0]        radius_a;
    logic [RAD_W-1:0]        radius_b;
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
  } req_t;

  // one layer table entry
  typedef struct packed {
    logic signed [CRD_W-1:0] cx;
    logic signed [CRD_W-1:0] cy;
    logic [RAD_W-1:0]        ra;
    logic [RAD_W-1:0]        rb;
    logic [SIDE_W-1:0]       sides;
  } shape_t;

  // one vertex table entry
  typedef struct packed {
    logic signed [CRD_W-1:0] vx;
    logic signed [CRD_W-1:0] vy;
  } vert_t;

  // back end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LRD,
    ST_ELL1,
    ST_ELL2,
    ST_ELL3,
    ST_ELL4,
    ST_VRD,
    ST_VGET,
    ST_TA,
    ST_TB,
    ST_TC,
    ST_NEXT,
    ST_DONE
  } bst_e;

endpackage

@@ src/layered_polygon_pixel_classifier.sv @@
// Layered polygon pixel classifier. Layer loads (tuser 0) and vertex loads
// (tuser 1) write the shape tables in the back end and give no result; a pixel
// request (tuser 2) gives one result: the lowest layer whose ellipse strictly
// holds the pixel and one of whose fan triangles holds it, else the outside
// flag. Per layer visited, a pixel costs an ellipse test and, when the pixel
// is inside the ellipse, a read per vertex from the vertex table plus an area
// test per fan triangle in the shared area unit; the walk stops at the first
// hit. A two entry request queue lets the input side keep accepting, until it
// is full, while the back end works, and a result register holds the answer
// until it is taken. tuser 3 is accepted and dropped.
module layered_polygon_pixel_classifier #(
  parameter int MAX_LAYERS = lppc_pkg::MAX_LAYERS_DEF,
  parameter int MAX_SIDES  = lppc_pkg::MAX_SIDES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lppc_pkg::LCNT_W-1:0]    cfg_data_i,     // layer_count
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // layer_sel, vertex_sel, side_total, coord_x, coord_y, radius_a, radius_b,
  // pixel_x, pixel_y
  input  logic [lppc_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic [lppc_pkg::S_TUSER_W-1:0] s_axis_tuser,   // req_type
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [lppc_pkg::M_TDATA_W-1:0] m_axis_tdata,   // hit_layer
  output logic [lppc_pkg::M_TUSER_W-1:0] m_axis_tuser    // outside
);
  import lppc_pkg::*;

  logic [LCNT_W-1:0] layer_count_q;
  logic              deq_valid;
  logic              deq_ready;
  req_t              deq_req;
  logic [HIT_W-1:0]  hit;
  logic              outside;

  // layer count register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_count_q <= LCNT_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      layer_count_q <= cfg_data_i;
    end
  end

  lppc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .deq_valid_o (deq_valid),
    .deq_ready_i (deq_ready),
    .deq_req_o   (deq_req)
  );

  lppc_back #(.MAX_LAYERS(MAX_LAYERS), .MAX_SIDES(MAX_SIDES)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .layer_count_i (layer_count_q),
    .deq_valid_i   (deq_valid),
    .deq_ready_o   (deq_ready),
    .deq_req_i     (deq_req),
    .m_tvalid_o    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_hit_o       (hit),
    .m_outside_o   (outside)
  );

  assign m_axis_tdata = M_TDATA_W'(hit);
  assign m_axis_tuser = M_TUSER_W'(outside);

endmodule

@@ src/lppc_ram.sv @@
// generic single write port ram with registered read
module lppc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/lppc_front.sv @@
// front end: takes stream transactions, decodes them and queues the requests
module lppc_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [lppc_pkg::S_TDATA_W-1:0] s_tdata_i,
  input  logic [lppc_pkg::S_TUSER_W-1:0] s_tuser_i,
  output logic                           deq_valid_o,
  input  logic                           deq_ready_i,
  output lppc_pkg::req_t                 deq_req_o
);
  import lppc_pkg::*;

  req_t       req_w;
  logic       keep_w;
  logic       push_w;
  logic       pop_w;
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q;
  logic       rp_q;
  req_t       buf_q [2];

  // unpack the transaction
  always_comb begin
    req_w.kind       = req_e'(s_tuser_i);
    req_w.layer_sel  = s_tdata_i[4:0];
    req_w.vertex_sel = s_tdata_i[11:5];
    req_w.side_total = s_tdata_i[19:12];
    req_w.coord_x    = s_tdata_i[35:20];
    req_w.coord_y    = s_tdata_i[51:36];
    req_w.radius_a   = s_tdata_i[66:52];
    req_w.radius_b   = s_tdata_i[81:67];
    req_w.pixel_x    = s_tdata_i[91:82];
    req_w.pixel_y    = s_tdata_i[101:92];
  end

  // the unused kind is taken and dropped
  always_comb begin
    case (req_w.kind)
      REQ_LAYER, REQ_VERTEX, REQ_PIXEL: keep_w = 1'b1;
      default:                          keep_w = 1'b0;
    endcase
  end

  assign s_tready_o  = (cnt_q != 2'd2);
  assign push_w      = s_tvalid_i && s_tready_o && keep_w;
  assign deq_valid_o = (cnt_q != 2'd0);
  assign pop_w       = deq_valid_o && deq_ready_i;
  assign deq_req_o   = buf_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_w && !pop_w) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_w && !push_w) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_w) begin
        wp_q <= ~wp_q;
      end
      if (pop_w) begin
        rp_q <= ~rp_q;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push_w) begin
      buf_q[wp_q] <= req_w;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("request queue count out of range");

  a_drop_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o && !keep_w && !pop_w) |=> $stable(cnt_q))
    else $error("unused request kind entered the queue");

endmodule

@@ src/lppc_back.sv @@
// back end: executes table loads and walks layer fans for pixel classification
module lppc_back #(
  parameter int MAX_LAYERS = lppc_pkg::MAX_LAYERS_DEF,
  parameter int MAX_SIDES  = lppc_pkg::MAX_SIDES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [lppc_pkg::LCNT_W-1:0] layer_count_i,
  input  logic                        deq_valid_i,
  output logic                        deq_ready_o,
  input  lppc_pkg::req_t              deq_req_i,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [lppc_pkg::HIT_W-1:0]  m_hit_o,
  output logic                        m_outside_o
);
  import lppc_pkg::*;

  localparam int LAW    = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int LCW    = $clog2(MAX_LAYERS + 1);
  localparam int VCW    = $clog2(MAX_SIDES + 1);
  localparam int VDEPTH = MAX_LAYERS * MAX_SIDES;
  localparam int VAW    = $clog2(VDEPTH);

  bst_e st_q, st_d;

  // walk control
  logic [LCW-1:0] layer_q;
  logic [LCW-1:0] count_w;
  logic [VCW-1:0] vidx_q;
  logic [VCW-1:0] nsd_q;
  logic           closing_q;
  logic           found_q;

  // pixel and layer shape
  logic signed [PXS_W-1:0] px_q, py_q;
  logic signed [DIF_W-1:0] qx_q, qy_q;
  logic [RAD_W-1:0]        ra_q, rb_q;

  // ellipse pipeline
  logic                    fail_q;
  logic [RAD_W-1:0]        ux_q, uy_q;
  logic [SQ_W-1:0]         ux2_q, uy2_q, ra2_q, rb2_q;
  logic [EP_W-1:0]         e1_q, e2_q, e3_q;
  logic                    inell_w;

  // fan triangle pipeline
  logic signed [CRD_W-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [CRD_W-1:0] ta_x_q, ta_y_q, tb_x_q, tb_y_q;
  logic signed [DIF_W-1:0] ax_q, ay_q, bx_q, by_q;
  logic signed [2*CRD_W-1:0] pw1_q, pw2_q;
  logic signed [PRD_W-1:0] p0a_q, p0b_q, p1a_q, p1b_q, p2a_q, p2b_q;
  logic signed [SUM_W-1:0] whole_w, parts_w;
  logic signed [CRS_W-1:0] c0_w, c1_w, c2_w;
  logic                    tri_hit_w;

  // shape decode
  shape_t                  shp_w;
  vert_t                   cur_w;
  logic signed [REL_W-1:0] dx_w, dy_w;
  logic [REL_W-1:0]        adx_w, ady_w;
  logic [VCW-1:0]          nsat_w;
  logic                    fail_w;

  // table ports
  logic              lay_we, lay_re, vert_we, vert_re;
  logic [LAW-1:0]    lay_waddr, lay_raddr;
  logic [VAW-1:0]    vert_waddr, vert_raddr;
  logic [$bits(shape_t)-1:0] lay_rdata;
  logic [$bits(vert_t)-1:0]  vert_rdata;
  shape_t            lay_wdata;
  vert_t             vert_wdata;
  logic              lsel_ok, vsel_ok;

  // result register
  logic              m_tvalid_q;
  logic [HIT_W-1:0]  hit_q;
  logic              outside_q;
  logic              res_load;

  // layers in use, saturated at the table size
  always_comb begin
    if ({1'b0, layer_count_i} > (LCNT_W + 1)'(MAX_LAYERS)) begin
      count_w = LCW'(MAX_LAYERS);
    end else begin
      count_w = LCW'(layer_count_i);
    end
  end

  assign lsel_ok = ({1'b0, deq_req_i.layer_sel} < (LSEL_W + 2)'(MAX_LAYERS));
  assign vsel_ok = ({2'b0, deq_req_i.vertex_sel} < (VSEL_W + 2)'(MAX_SIDES));

  // tables
  assign lay_waddr  = LAW'(deq_req_i.layer_sel);
  assign lay_wdata  = '{cx: deq_req_i.coord_x, cy: deq_req_i.coord_y,
                        ra: deq_req_i.radius_a, rb: deq_req_i.radius_b,
                        sides: deq_req_i.side_total};
  assign lay_raddr  = layer_q[LAW-1:0];
  assign vert_waddr = VAW'(deq_req_i.layer_sel * MAX_SIDES + deq_req_i.vertex_sel);
  assign vert_wdata = '{vx: deq_req_i.coord_x, vy: deq_req_i.coord_y};
  assign vert_raddr = VAW'(layer_q * MAX_SIDES + vidx_q);

  lppc_ram #(.WIDTH($bits(shape_t)), .DEPTH(MAX_LAYERS)) u_layer_ram (
    .clk_i   (clk_i),
    .we_i    (lay_we),
    .waddr_i (lay_waddr),
    .wdata_i (lay_wdata),
    .re_i    (lay_re),
    .raddr_i (lay_raddr),
    .rdata_o (lay_rdata)
  );

  lppc_ram #(.WIDTH($bits(vert_t)), .DEPTH(VDEPTH)) u_vertex_ram (
    .clk_i   (clk_i),
    .we_i    (vert_we),
    .waddr_i (vert_waddr),
    .wdata_i (vert_wdata),
    .re_i    (vert_re),
    .raddr_i (vert_raddr),
    .rdata_o (vert_rdata)
  );

  // layer entry decode and early ellipse rejection
  always_comb begin
    shp_w = shape_t'(lay_rdata);
    cur_w = vert_t'(vert_rdata);
    dx_w  = REL_W'(px_q) - REL_W'(shp_w.cx);
    dy_w  = REL_W'(py_q) - REL_W'(shp_w.cy);
    adx_w = dx_w[REL_W-1] ? REL_W'(-dx_w) : REL_W'(dx_w);
    ady_w = dy_w[REL_W-1] ? REL_W'(-dy_w) : REL_W'(dy_w);
    if ({1'b0, shp_w.sides} > (SIDE_W + 2)'(MAX_SIDES)) begin
      nsat_w = VCW'(MAX_SIDES);
    end else begin
      nsat_w = VCW'(shp_w.sides);
    end
    fail_w = (adx_w >= REL_W'(shp_w.ra)) || (ady_w >= REL_W'(shp_w.rb)) ||
             (nsat_w == '0);
  end

  assign inell_w = !fail_q && ((ES_W'(e1_q) + ES_W'(e2_q)) < ES_W'(e3_q));

  // triangle area compare
  always_comb begin
    c0_w      = CRS_W'(p0a_q) - CRS_W'(p0b_q);
    c1_w      = CRS_W'(p1a_q) - CRS_W'(p1b_q);
    c2_w      = CRS_W'(p2a_q) - CRS_W'(p2b_q);
    whole_w   = SUM_W'(pw1_q) - SUM_W'(pw2_q);
    parts_w   = SUM_W'(c0_w[CRS_W-1] ? -c0_w : c0_w)
              + SUM_W'(c1_w[CRS_W-1] ? -c1_w : c1_w)
              + SUM_W'(c2_w[CRS_W-1] ? -c2_w : c2_w);
    tri_hit_w = (whole_w == parts_w);
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (deq_valid_i && (deq_req_i.kind == REQ_PIXEL)) begin
          st_d = (count_w == '0) ? ST_DONE : ST_LRD;
        end
      end
      ST_LRD:  st_d = ST_ELL1;
      ST_ELL1: st_d = ST_ELL2;
      ST_ELL2: st_d = ST_ELL3;
      ST_ELL3: st_d = ST_ELL4;
      ST_ELL4: st_d = inell_w ? ST_VRD : ST_NEXT;
      ST_VRD:  st_d = ST_VGET;
      ST_VGET: begin
        if ((vidx_q == '0) && (nsd_q > VCW'(1))) begin
          st_d = ST_VRD;
        end else begin
          st_d = ST_TA;
        end
      end
      ST_TA:   st_d = ST_TB;
      ST_TB:   st_d = ST_TC;
      ST_TC: begin
        if (tri_hit_w) begin
          st_d = ST_DONE;
        end else if (closing_q) begin
          st_d = ST_NEXT;
        end else if (vidx_q < nsd_q) begin
          st_d = ST_VRD;
        end else begin
          st_d = ST_TA;
        end
      end
      ST_NEXT: begin
        if (((LCW + 1)'(layer_q) + (LCW + 1)'(1)) >= (LCW + 1)'(count_w)) begin
          st_d = ST_DONE;
        end else begin
          st_d = ST_LRD;
        end
      end
      ST_DONE: begin
        if (!m_tvalid_q || m_tready_i) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    deq_ready_o = 1'b0;
    lay_we      = 1'b0;
    vert_we     = 1'b0;
    lay_re      = 1'b0;
    vert_re     = 1'b0;
    res_load    = 1'b0;
    case (st_q)
      ST_IDLE: begin
        deq_ready_o = 1'b1;
        lay_we  = deq_valid_i && (deq_req_i.kind == REQ_LAYER) && lsel_ok;
        vert_we = deq_valid_i && (deq_req_i.kind == REQ_VERTEX) && lsel_ok && vsel_ok;
      end
      ST_LRD:  lay_re   = 1'b1;
      ST_VRD:  vert_re  = 1'b1;
      ST_DONE: res_load = !m_tvalid_q || m_tready_i;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      m_tvalid_q <= 1'b0;
      found_q    <= 1'b0;
      closing_q  <= 1'b0;
    end else begin
      st_q <= st_d;
      if (res_load) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
      if ((st_q == ST_IDLE) && deq_valid_i) begin
        found_q <= 1'b0;
      end else if ((st_q == ST_TC) && tri_hit_w) begin
        found_q <= 1'b1;
      end
      if (st_q == ST_ELL1) begin
        closing_q <= 1'b0;
      end else if ((st_q == ST_VGET) && (vidx_q == '0) && (nsd_q == VCW'(1))) begin
        closing_q <= 1'b1;
      end else if ((st_q == ST_TC) && !closing_q && (vidx_q >= nsd_q)) begin
        closing_q <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        px_q    <= PXS_W'(deq_req_i.pixel_x) <<< FRAC_BITS;
        py_q    <= PXS_W'(deq_req_i.pixel_y) <<< FRAC_BITS;
        layer_q <= '0;
      end
      ST_ELL1: begin
        qx_q   <= DIF_W'(-dx_w);
        qy_q   <= DIF_W'(-dy_w);
        ra_q   <= shp_w.ra;
        rb_q   <= shp_w.rb;
        nsd_q  <= nsat_w;
        fail_q <= fail_w;
        ux_q   <= adx_w[RAD_W-1:0];
        uy_q   <= ady_w[RAD_W-1:0];
        vidx_q <= '0;
      end
      ST_ELL2: begin
        ux2_q <= SQ_W'(ux_q) * SQ_W'(ux_q);
        uy2_q <= SQ_W'(uy_q) * SQ_W'(uy_q);
        ra2_q <= SQ_W'(ra_q) * SQ_W'(ra_q);
        rb2_q <= SQ_W'(rb_q) * SQ_W'(rb_q);
      end
      ST_ELL3: begin
        e1_q <= EP_W'(ux2_q) * EP_W'(rb2_q);
        e2_q <= EP_W'(uy2_q) * EP_W'(ra2_q);
        e3_q <= EP_W'(ra2_q) * EP_W'(rb2_q);
      end
      ST_VGET: begin
        vidx_q <= vidx_q + VCW'(1);
        if (vidx_q == '0) begin
          first_x_q <= cur_w.vx;
          first_y_q <= cur_w.vy;
          prev_x_q  <= cur_w.vx;
          prev_y_q  <= cur_w.vy;
          ta_x_q    <= cur_w.vx;
          ta_y_q    <= cur_w.vy;
          tb_x_q    <= cur_w.vx;
          tb_y_q    <= cur_w.vy;
        end else begin
          ta_x_q   <= prev_x_q;
          ta_y_q   <= prev_y_q;
          tb_x_q   <= cur_w.vx;
          tb_y_q   <= cur_w.vy;
          prev_x_q <= cur_w.vx;
          prev_y_q <= cur_w.vy;
        end
      end
      ST_TA: begin
        ax_q <= qx_q + DIF_W'(ta_x_q);
        ay_q <= qy_q + DIF_W'(ta_y_q);
        bx_q <= qx_q + DIF_W'(tb_x_q);
        by_q <= qy_q + DIF_W'(tb_y_q);
      end
      ST_TB: begin
        pw1_q <= (2*CRD_W)'(ta_x_q) * (2*CRD_W)'(tb_y_q);
        pw2_q <= (2*CRD_W)'(ta_y_q) * (2*CRD_W)'(tb_x_q);
        p0a_q <= PRD_W'(qx_q) * PRD_W'(ay_q);
        p0b_q <= PRD_W'(qy_q) * PRD_W'(ax_q);
        p1a_q <= PRD_W'(ax_q) * PRD_W'(by_q);
        p1b_q <= PRD_W'(ay_q) * PRD_W'(bx_q);
        p2a_q <= PRD_W'(bx_q) * PRD_W'(qy_q);
        p2b_q <= PRD_W'(by_q) * PRD_W'(qx_q);
      end
      ST_TC: begin
        // closing triangle of the fan pairs the last vertex with the first
        if (!tri_hit_w && !closing_q && (vidx_q >= nsd_q)) begin
          ta_x_q <= prev_x_q;
          ta_y_q <= prev_y_q;
          tb_x_q <= first_x_q;
          tb_y_q <= first_y_q;
        end
      end
      ST_NEXT: layer_q <= layer_q + LCW'(1);
      default: ;
    endcase
    if (res_load) begin
      hit_q     <= found_q ? HIT_W'(layer_q) : '0;
      outside_q <= !found_q;
    end
  end

  assign m_tvalid_o  = m_tvalid_q;
  assign m_hit_o     = hit_q;
  assign m_outside_o = outside_q;

  a_vertex_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_VGET) |-> (vidx_q < nsd_q))
    else $error("vertex read beyond the side count");

  a_closing_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_TC && closing_q) |-> (vidx_q == nsd_q))
    else $error("closing triangle before all vertices were read");

  a_hit_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DONE && found_q) |-> (layer_q < count_w))
    else $error("hit layer outside the layers in use");

endmodule

@@ tb/sv/layered_polygon_pixel_classifier_tb.sv @@
// testbench of the layered polygon pixel classifier: shape loads, pixel checks
`timescale 1ns / 100ps

module layered_polygon_pixel_classifier_tb;
  import lppc_pkg::*;

  localparam int          NLAYER     = MAX_LAYERS_DEF;
  localparam int          NSIDE      = MAX_SIDES_DEF;
  localparam logic [1:0]  REQ_SPARE  = 2'd3;
  localparam int          IDLE_PCT   = 24;
  localparam int          STALL_LIMIT = 100000;
  localparam int          SETTLE_CYC = 40;
  localparam int          PHASE_ITEMS = 190;

  // one stream request as the generator builds it
  typedef struct {
    logic [1:0]              kind;
    logic [LSEL_W-1:0]       lsel;
    logic [VSEL_W-1:0]       vsel;
    logic [SIDE_W-1:0]       sides;
    logic signed [CRD_W-1:0] cx;
    logic signed [CRD_W-1:0] cy;
    logic [RAD_W-1:0]        ra;
    logic [RAD_W-1:0]        rb;
    logic signed [PIX_W-1:0] px;
    logic signed [PIX_W-1:0] py;
  } shape_req_t;

  typedef struct {
    logic [HIT_W-1:0] hit_layer;
    logic             outside;
  } verdict_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [LCNT_W-1:0]    cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;

  layered_polygon_pixel_classifier u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  shape_req_t pending_reqs[$];
  verdict_t   verdict_q[$];
  shape_req_t cur_req;
  int         mismatches = 0;
  int         cycle_no = 0;
  bit         in_fire, out_fire;

  // shadow copy of the shape tables and the layer count
  logic [LCNT_W-1:0]       shd_count = 6'd1;
  logic signed [CRD_W-1:0] shd_cx[NLAYER];
  logic signed [CRD_W-1:0] shd_cy[NLAYER];
  logic [RAD_W-1:0]        shd_ra[NLAYER];
  logic [RAD_W-1:0]        shd_rb[NLAYER];
  logic [SIDE_W-1:0]       shd_sides[NLAYER];
  logic signed [CRD_W-1:0] shd_vx[NLAYER*NSIDE];
  logic signed [CRD_W-1:0] shd_vy[NLAYER*NSIDE];

  // generator side knowledge of what is loaded
  int  gen_cx[NLAYER], gen_cy[NLAYER], gen_r[NLAYER];
  bit  vert_done[NLAYER][NSIDE];
  int  gen_count = 1;
  int  items_made = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_no, what, got, want);
    mismatches++;
  endtask

  function automatic longint cross2(longint ax, longint ay, longint bx, longint by);
    return ax * by - ay * bx;
  endfunction

  function automatic longint absl(longint a);
    return (a < 0) ? -a : a;
  endfunction

  // exact strict ellipse containment
  function automatic bit in_ellipse(longint dx, longint dy, longint ra, longint rb);
    longint unsigned ux, uy;
    ux = absl(dx);
    uy = absl(dy);
    if (ux >= ra || uy >= rb) return 1'b0;
    return ux * ux * rb * rb + uy * uy * ra * ra < ra * ra * rb * rb;
  endfunction

  // signed area equal to the sum of the sub-area magnitudes
  function automatic bit in_triangle(longint x0, longint y0, longint x1, longint y1,
                                     longint x2, longint y2, longint px, longint py);
    longint whole, parts;
    whole = cross2(x1 - x0, y1 - y0, x2 - x0, y2 - y0);
    parts = absl(cross2(x0 - px, y0 - py, x1 - px, y1 - py))
          + absl(cross2(x1 - px, y1 - py, x2 - px, y2 - py))
          + absl(cross2(x2 - px, y2 - py, x0 - px, y0 - py));
    return whole == parts;
  endfunction

  function automatic verdict_t classify_pixel(logic signed [PIX_W-1:0] pxi,
                                              logic signed [PIX_W-1:0] pyi);
    verdict_t v;
    longint px, py, cx, cy;
    int n, cnt, a, b;
    bit hit;
    v.hit_layer = '0;
    v.outside = 1'b1;
    px = longint'(pxi) * (1 << FRAC_BITS);
    py = longint'(pyi) * (1 << FRAC_BITS);
    cnt = (shd_count > NLAYER) ? NLAYER : shd_count;
    for (int l = 0; l < cnt; l++) begin
      cx = shd_cx[l];
      cy = shd_cy[l];
      n = (shd_sides[l] > NSIDE) ? NSIDE : shd_sides[l];
      hit = 1'b0;
      if (in_ellipse(px - cx, py - cy, shd_ra[l], shd_rb[l])) begin
        for (int k = 0; k < n && !hit; k++) begin
          a = l * NSIDE + k;
          b = l * NSIDE + (k + 1) % n;
          hit = in_triangle(cx, cy, cx + shd_vx[a], cy + shd_vy[a],
                            cx + shd_vx[b], cy + shd_vy[b], px, py);
        end
      end
      if (hit) begin
        v.hit_layer = l[HIT_W-1:0];
        v.outside = 1'b0;
        return v;
      end
    end
    return v;
  endfunction

  // ---------------------------------------------------------------- generator

  function automatic shape_req_t random_req(logic [1:0] kind);
    shape_req_t r;
    r.kind  = kind;
    r.lsel  = LSEL_W'($urandom);
    r.vsel  = VSEL_W'($urandom);
    r.sides = SIDE_W'($urandom);
    r.cx    = CRD_W'($urandom);
    r.cy    = CRD_W'($urandom);
    r.ra    = RAD_W'($urandom);
    r.rb    = RAD_W'($urandom);
    r.px    = PIX_W'($urandom);
    r.py    = PIX_W'($urandom);
    return r;
  endfunction

  task automatic push_req(input shape_req_t r);
    pending_reqs.push_back(r);
    if (r.kind != REQ_SPARE) items_made++;
    if (r.kind == REQ_VERTEX) vert_done[r.lsel][r.vsel] = 1'b1;
  endtask

  task automatic push_vertex(input int l, input int k, input int vx, input int vy);
    shape_req_t r;
    r = random_req(REQ_VERTEX);
    r.lsel = LSEL_W'(l);
    r.vsel = VSEL_W'(k);
    r.cx = CRD_W'(vx);
    r.cy = CRD_W'(vy);
    push_req(r);
  endtask

  // make sure every vertex the fan can read has been written
  task automatic fill_missing(input int l, input int sides);
    int n;
    n = (sides > NSIDE) ? NSIDE : sides;
    for (int k = 0; k < n; k++)
      if (!vert_done[l][k]) push_vertex(l, k, $urandom_range(0, 4000) - 2000,
                                        $urandom_range(0, 4000) - 2000);
  endtask

  // layer shape plus a regular polygon fan, wound either way
  task automatic load_polygon(input int l, input int sides, input int cx, input int cy,
                              input int ra, input int rb, input int pr, input bit cw);
    shape_req_t r;
    int n;
    real ang;
    r = random_req(REQ_LAYER);
    r.lsel = LSEL_W'(l);
    r.sides = SIDE_W'(sides);
    r.cx = CRD_W'(cx);
    r.cy = CRD_W'(cy);
    r.ra = RAD_W'(ra);
    r.rb = RAD_W'(rb);
    push_req(r);
    gen_cx[l] = cx;
    gen_cy[l] = cy;
    gen_r[l] = (ra > rb) ? ra : rb;
    n = (sides > NSIDE) ? NSIDE : sides;
    for (int k = 0; k < n; k++) begin
      ang = 6.283185307179586 * k / n;
      if (cw) ang = -ang;
      push_vertex(l, k, $rtoi(pr * $cos(ang)), $rtoi(pr * $sin(ang)));
    end
  endtask

  task automatic random_polygon(input int l);
    int rad;
    rad = $urandom_range(300, 3000);
    load_polygon(l, $urandom_range(3, 10), $urandom_range(0, 12000) - 6000,
                 $urandom_range(0, 12000) - 6000, rad + $urandom_range(0, 200),
                 rad + $urandom_range(0, 200), rad * $urandom_range(60, 110) / 100,
                 $urandom_range(0, 9) == 0);
  endtask

  task automatic push_pixel(input int x, input int y);
    shape_req_t r;
    r = random_req(REQ_PIXEL);
    r.px = PIX_W'(x);
    r.py = PIX_W'(y);
    push_req(r);
  endtask

  task automatic pixel_near(input int l);
    int span;
    span = gen_r[l] / 16 + 2;
    push_pixel((gen_cx[l] >>> 4) + $urandom_range(0, 2 * span) - span,
               (gen_cy[l] >>> 4) + $urandom_range(0, 2 * span) - span);
  endtask

  task automatic random_mix(input int count);
    shape_req_t r;
    int pick, l, lim, sides;
    lim = items_made + count;
    while (items_made < lim) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        l = (gen_count > NLAYER) ? NLAYER : gen_count;
        if (l == 0 || $urandom_range(0, 4) == 0) begin
          r = random_req(REQ_PIXEL);
          push_req(r);
        end else pixel_near($urandom_range(0, l - 1));
      end else if (pick < 75) begin
        random_polygon($urandom_range(0, NLAYER - 1));
      end else if (pick < 85) begin
        // disturb one vertex, mildly or wildly
        r = random_req(REQ_VERTEX);
        if ($urandom_range(0, 1)) begin
          r.cx = CRD_W'($urandom_range(0, 6000) - 3000);
          r.cy = CRD_W'($urandom_range(0, 6000) - 3000);
        end
        push_req(r);
      end else if (pick < 93) begin
        // layer load with random fields
        r = random_req(REQ_LAYER);
        if ($urandom_range(0, 3) != 0) r.sides = SIDE_W'($urandom_range(0, 10));
        if ($urandom_range(0, 1)) begin
          r.cx = CRD_W'($urandom_range(0, 12000) - 6000);
          r.cy = CRD_W'($urandom_range(0, 12000) - 6000);
          r.ra = RAD_W'($urandom_range(0, 4000));
          r.rb = RAD_W'($urandom_range(0, 4000));
        end
        push_req(r);
        gen_cx[r.lsel] = r.cx;
        gen_cy[r.lsel] = r.cy;
        gen_r[r.lsel] = (r.ra > r.rb) ? r.ra : r.rb;
        fill_missing(r.lsel, r.sides);
      end else if (pick < 96) begin
        push_req(random_req(REQ_SPARE));
      end else begin
        push_req(random_req(REQ_VERTEX));
      end
    end
  endtask

  // ------------------------------------------------------------ phase control

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || s_axis_tvalid || verdict_q.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_count(input int value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= LCNT_W'(value);
    do @(posedge clk_i);
    while (!cfg_ready_o);
    shd_count = LCNT_W'(value);
    gen_count = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int counts[7];
    counts = '{0, 63, 32, 2, 17, 1, 40};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // every layer gets a shape and its vertices before any pixel
    for (int l = 0; l < NLAYER; l++) random_polygon(l);
    // special shapes: zero radius, no sides, saturated sides, clockwise, degenerate
    load_polygon(1, 4, 0, 0, 0, 2000, 1500, 1'b0);
    load_polygon(2, 0, 1600, 1600, 2000, 2000, 1500, 1'b0);
    load_polygon(3, 255, -3200, 3200, 32767, 32767, 2000, 1'b0);
    load_polygon(4, 6, 3200, -3200, 2000, 2000, 1800, 1'b1);
    load_polygon(5, 3, -4800, 512, 1600, 1600, 0, 1'b0);
    for (int k = 0; k < 3; k++) push_vertex(5, k, (k + 1) * 320, 0);
    load_polygon(31, 8, 32767, -32768, 32767, 32767, 30000, 1'b0);
    push_vertex(31, 127, -32768, 32767);

    // reset layer count is one: layer zero only
    pixel_near(0);
    pixel_near(0);
    random_mix(PHASE_ITEMS);
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      write_count(counts[p]);
      if (p == 1) begin
        pixel_near(1);
        push_pixel(100, 100);
        pixel_near(3);
        push_pixel(-200, 200);
        pixel_near(4);
        push_pixel(200, -200);
        push_pixel(-290, 32);
        push_pixel(-300, 32);
        push_pixel(-512, -512);
        push_pixel(511, 511);
        push_pixel(-512, 511);
        push_pixel(511, -512);
      end
      random_mix(PHASE_ITEMS);
      wait_drained();
    end

    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // ----------------------------------------------------------- driver, monitor

  function automatic bit idle_now();
    return !(cycle_no >= 4000 && cycle_no < 12000) && $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  // input transaction source, updated on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (pending_reqs.size() != 0 && !idle_now()) begin
        cur_req = pending_reqs.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cur_req.kind;
        s_axis_tdata <= {2'b00, cur_req.py, cur_req.px, cur_req.rb, cur_req.ra, cur_req.cy,
                         cur_req.cx, cur_req.sides, cur_req.vsel, cur_req.lsel};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= rst_ni && !idle_now();
  end

  // accepted transactions: update shadow state, predict and check results
  always @(posedge clk_i) begin
    verdict_t want;
    int idx;
    cycle_no++;
    in_fire = s_axis_tvalid && s_axis_tready;
    out_fire = m_axis_tvalid && m_axis_tready;
    if (in_fire) begin
      case (cur_req.kind)
        REQ_LAYER: begin
          shd_cx[cur_req.lsel] = cur_req.cx;
          shd_cy[cur_req.lsel] = cur_req.cy;
          shd_ra[cur_req.lsel] = cur_req.ra;
          shd_rb[cur_req.lsel] = cur_req.rb;
          shd_sides[cur_req.lsel] = cur_req.sides;
        end
        REQ_VERTEX: begin
          idx = cur_req.lsel * NSIDE + cur_req.vsel;
          shd_vx[idx] = cur_req.cx;
          shd_vy[idx] = cur_req.cy;
        end
        REQ_PIXEL: verdict_q.push_back(classify_pixel(cur_req.px, cur_req.py));
        default: ;
      endcase
    end
    if (out_fire) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected result, hit_layer", m_axis_tdata[HIT_W-1:0], -1);
      end else begin
        want = verdict_q.pop_front();
        if (m_axis_tdata[HIT_W-1:0] != want.hit_layer)
          report_mismatch("hit_layer", m_axis_tdata[HIT_W-1:0], want.hit_layer);
        if (m_axis_tuser[0] != want.outside)
          report_mismatch("outside", m_axis_tuser[0], want.outside);
      end
    end
  end

  // watchdog on cycles without any transaction
  int stall_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout at cycle %0d", cycle_no);
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
